// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file of this project.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted (active low).
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked in every cycle, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/laf_pkg.sv =====
// Shared types, constants and saturating arithmetic of the LMS adaptive FIR.
// No dependencies; imported by lms_adaptive_fir, laf_port_checker and the testbench.
package laf_pkg;

  localparam int LAF_TAPS    = 8;
  localparam int SMP_W       = 16;
  localparam int ERR_W       = 17;
  localparam int WGT_W       = 64;
  localparam int SHIFT_W     = 6;
  localparam int PROD_W      = 48;
  localparam int UPD_P_W     = 33;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_LSB = SMP_W + ERR_W;

  localparam logic [SHIFT_W-1:0] STEP_RESET = 6'd37;
  localparam logic [SHIFT_W-1:0] FRAC_BITS  = 6'd48;

  typedef logic signed [SMP_W-1:0]   smp_t;
  typedef logic signed [ERR_W-1:0]   err_t;
  typedef logic signed [WGT_W-1:0]   wgt_t;
  typedef logic signed [UPD_P_W-1:0] upd_p_t;
  typedef logic [SHIFT_W-1:0]        shift_t;

  localparam wgt_t WGT_MAX = {1'b0, {(WGT_W-1){1'b1}}};
  localparam wgt_t WGT_MIN = {1'b1, {(WGT_W-1){1'b0}}};

  // a + b, clamped to the signed 64-bit range.
  function automatic wgt_t sat_add64(wgt_t a, wgt_t b);
    logic signed [WGT_W:0] s;
    s = {a[WGT_W-1], a} + {b[WGT_W-1], b};
    if (s[WGT_W] != s[WGT_W-1]) begin
      return a[WGT_W-1] ? WGT_MIN : WGT_MAX;
    end
    return s[WGT_W-1:0];
  endfunction

  // Weight step for product p: p * 2^(48 - sh) saturated for sh up to 48,
  // floor(p / 2^(sh - 48)) above that.
  function automatic wgt_t weight_delta(upd_p_t p, shift_t sh);
    logic signed [UPD_P_W+47:0] ext;
    logic signed [UPD_P_W+47:0] shl;
    upd_p_t                     shr;
    shift_t                     k;
    ext = {{48{p[UPD_P_W-1]}}, p};
    if (sh <= FRAC_BITS) begin
      k   = FRAC_BITS - sh;
      shl = ext <<< k;
      if (shl[UPD_P_W+47:WGT_W-1] != {(UPD_P_W+49-WGT_W){shl[WGT_W-1]}}) begin
        return p[UPD_P_W-1] ? WGT_MIN : WGT_MAX;
      end
      return shl[WGT_W-1:0];
    end
    shr = p >>> (sh - FRAC_BITS);
    return {{(WGT_W-UPD_P_W){shr[UPD_P_W-1]}}, shr};
  endfunction

endpackage

// ===== hdl/lms_adaptive_fir.sv =====
// LMS adaptive FIR filter: one item in, one filtered sample and error out.
// Depends on laf_pkg. A new item is taken only once the previous one has
// been filtered, emitted and used to update the weights. Each state memory
// has a single read port: one tap per cycle while filtering, then one tap
// per cycle while updating. Synchronous active-low reset clears
// the delay line and weights (through per-entry valid bits) and sets step_shift to 37.
module lms_adaptive_fir #(
  parameter int TAPS = laf_pkg::LAF_TAPS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [15:0] new_sample, [31:16] desired
  input  logic [laf_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [15:0] filter_out, [32:16] error_out, [39:33] zero
  output logic [laf_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                              cfg_wr_en,
  input  logic [laf_pkg::SHIFT_W-1:0]       cfg_wr_data
);
  import laf_pkg::*;

  // The delay line is a circular buffer: newest_r points at the newest
  // sample, and tap i lives at newest_r - i (mod TAPS). The weights sit in a
  // second memory indexed directly by tap number. Both reset to zero through
  // valid bits; an entry that was never written reads as zero.
  localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int CW = $clog2(TAPS + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TAPS - 1);
  localparam logic [CW-1:0] TAPS_CNT  = CW'(TAPS);

  // IDLE waits for an item, FILT runs the multiply-accumulate over the taps,
  // EMIT forms y and the error and hands them to the output register, UPD
  // walks the taps again and writes back the adapted weights.
  typedef enum logic [1:0] {
    S_IDLE,
    S_FILT,
    S_EMIT,
    S_UPD
  } state_t;

  state_t state_r;
  shift_t step_shift_r;

  logic [AW-1:0] newest_r;
  logic [AW-1:0] newest_nxt;
  logic [AW-1:0] saddr_r;
  logic [CW-1:0] cnt_r;
  logic          issue;

  smp_t smp_mem [TAPS];
  wgt_t wgt_mem [TAPS];
  logic [TAPS-1:0] smp_vld_r;
  logic [TAPS-1:0] wgt_vld_r;

  smp_t smp_rd_r;
  wgt_t wgt_rd_r;
  logic smp_rd_vld_r;
  logic wgt_rd_vld_r;
  smp_t smp_q;
  wgt_t wgt_q;

  // Tap pipeline: stage 1 holds fresh read data, stage 2 the product,
  // stage 3 (update only) the step ready to be added and written back.
  logic          st1_v_r;
  logic          st2_v_r;
  logic          st3_v_r;
  logic [AW-1:0] st1_idx_r;
  logic [AW-1:0] st2_idx_r;
  logic [AW-1:0] st3_idx_r;

  logic signed [31:0]       wgt_hi;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;
  wgt_t                     acc_r;
  smp_t                     desired_r;

  upd_p_t p_nxt;
  upd_p_t p_r;
  err_t   err_r;
  wgt_t   wgt2_r;
  wgt_t   wgt3_r;
  wgt_t   delta_r;
  wgt_t   wgt_new;
  logic   wgt_we;
  logic   smp_we;

  logic signed [WGT_W-17:0] y_full;
  smp_t                     y_sat;
  err_t                     err_nxt;
  logic                     out_free;

  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign newest_nxt = (newest_r == LAST_ADDR) ? '0 : newest_r + 1'b1;
  assign smp_we     = in_tvalid && in_tready;
  assign issue      = ((state_r == S_FILT) || (state_r == S_UPD)) && (cnt_r != TAPS_CNT);

  // Entries never written read as zero.
  assign smp_q = smp_rd_vld_r ? smp_rd_r : '0;
  assign wgt_q = wgt_rd_vld_r ? wgt_rd_r : '0;

  // Filter product: Q16.16 weight (upper half of Q16.48) times the sample.
  assign wgt_hi   = wgt_q[WGT_W-1:32];
  assign prod_nxt = wgt_hi * smp_q;

  // Update product: error times the same sample the filter used.
  assign p_nxt = err_r * smp_q;

  // During the update pass each weight is read once and written back from
  // stage 3, and the next item's filter pass starts only after the last write,
  // so read and write of the same entry never overlap.
  assign wgt_new = sat_add64(wgt3_r, delta_r);
  assign wgt_we  = (state_r == S_UPD) && st3_v_r;

  // y = floor(acc / 2^16), clamped to 16 bits; the error uses the clamped y.
  assign y_full = acc_r[WGT_W-1:16];
  always_comb begin
    if (y_full[WGT_W-17:SMP_W-1] == {(WGT_W-16-SMP_W+1){y_full[WGT_W-17]}}) begin
      y_sat = y_full[SMP_W-1:0];
    end else if (y_full[WGT_W-17]) begin
      y_sat = {1'b1, {(SMP_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SMP_W-1){1'b1}}};
    end
  end
  assign err_nxt  = {desired_r[SMP_W-1], desired_r} - {y_sat[SMP_W-1], y_sat};
  assign out_free = !out_tvalid_r || out_tready;

  // State memories: one write and one registered read per cycle each.
  always_ff @(posedge clk) begin
    if (smp_we) begin
      smp_mem[newest_nxt] <= in_tdata[SMP_W-1:0];
    end
    if (wgt_we) begin
      wgt_mem[st3_idx_r] <= wgt_new;
    end
    if (issue) begin
      smp_rd_r <= smp_mem[saddr_r];
      wgt_rd_r <= wgt_mem[cnt_r[AW-1:0]];
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    p_r     <= p_nxt;
    wgt2_r  <= wgt_q;
    delta_r <= weight_delta(p_r, step_shift_r);
    wgt3_r  <= wgt2_r;
    st2_idx_r <= st1_idx_r;
    st3_idx_r <= st2_idx_r;
    if (issue) begin
      st1_idx_r <= cnt_r[AW-1:0];
    end
    if (smp_we) begin
      desired_r <= in_tdata[2*SMP_W-1:SMP_W];
      acc_r     <= '0;
    end else if ((state_r == S_FILT) && st2_v_r) begin
      acc_r <= sat_add64(acc_r, {{(WGT_W-PROD_W){prod_r[PROD_W-1]}}, prod_r});
    end
    if ((state_r == S_EMIT) && out_free) begin
      err_r       <= err_nxt;
      out_tdata_r <= {{(OUT_TDATA_W-OUT_PAD_LSB){1'b0}}, err_nxt, y_sat};
    end
  end

  // Control: state, counters, valid bits and the output handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      step_shift_r <= STEP_RESET;
      newest_r     <= '0;
      saddr_r      <= '0;
      cnt_r        <= '0;
      smp_vld_r    <= '0;
      wgt_vld_r    <= '0;
      smp_rd_vld_r <= 1'b0;
      wgt_rd_vld_r <= 1'b0;
      st1_v_r      <= 1'b0;
      st2_v_r      <= 1'b0;
      st3_v_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        step_shift_r <= cfg_wr_data;
      end
      st1_v_r <= issue;
      st2_v_r <= st1_v_r;
      st3_v_r <= st2_v_r;
      if (issue) begin
        smp_rd_vld_r <= smp_vld_r[saddr_r];
        wgt_rd_vld_r <= wgt_vld_r[cnt_r[AW-1:0]];
        cnt_r        <= cnt_r + 1'b1;
        saddr_r      <= (saddr_r == '0) ? LAST_ADDR : saddr_r - 1'b1;
      end
      if (wgt_we) begin
        wgt_vld_r[st3_idx_r] <= 1'b1;
      end
      // A new result enters the output register as the old one leaves it.
      if ((state_r == S_EMIT) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (smp_we) begin
            newest_r              <= newest_nxt;
            smp_vld_r[newest_nxt] <= 1'b1;
            saddr_r               <= newest_nxt;
            cnt_r                 <= '0;
            state_r               <= S_FILT;
          end
        end
        S_FILT: begin
          if ((cnt_r == TAPS_CNT) && !st1_v_r && !st2_v_r) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            saddr_r      <= newest_r;
            cnt_r        <= '0;
            state_r      <= S_UPD;
          end
        end
        S_UPD: begin
          if ((cnt_r == TAPS_CNT) && !st1_v_r && !st2_v_r && !st3_v_r) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/laf_port_checker.sv =====
// Port-level checks for lms_adaptive_fir, attached by the bind at the end.
// Depends on laf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module laf_port_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [laf_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [laf_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            cfg_wr_en,
  input logic [laf_pkg::SHIFT_W-1:0]     cfg_wr_data
);
  import laf_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_r;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // Items accepted whose results are not yet taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  `ASSERT_CLK(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")
  `ASSERT_CLK(a_one_at_a_time, clk, rst_n, in_acc |=> !in_tready, "item accepted while one is in work")
  `ASSERT_CLK(a_no_invented, clk, rst_n, out_tvalid |-> pend_r != 2'd0, "result without an item")
  `ASSERT_CLK(a_pend_bound, clk, rst_n, pend_r != 2'd3, "too many items in flight")
  `ASSERT_CLK(a_out_range, clk, rst_n, out_tvalid |-> out_tdata[OUT_TDATA_W-1:OUT_PAD_LSB] == '0 && out_tdata[OUT_PAD_LSB-1:SMP_W] != 17'h10000, "error field out of range")

  logic unused_in;
  assign unused_in = ^{in_tdata, cfg_wr_en, cfg_wr_data};

endmodule

bind lms_adaptive_fir laf_port_checker u_laf_port_checker (.*);

// ===== verif/lms_adaptive_fir_test.sv =====
// Self-checking testbench for lms_adaptive_fir: streams sample/desired items, predicts
// every filter output and error in the bench, and compares them with what the block returns.
// Depends on laf_pkg and lms_adaptive_fir.
module lms_adaptive_fir_test;
  import laf_pkg::*;

  localparam int  TAPS       = LAF_TAPS;
  // Generous timeout.
  localparam int  CYCLE_LIMIT = 2_000_000;
  // Quiet time before a register write and at the end, a little over the latency.
  localparam int  SETTLE     = TAPS + 8;
  localparam int  PHASE_LEN  = 150;
  localparam longint W_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint W_MIN   = 64'sh8000_0000_0000_0000;

  // One expected result: the saturated filter output and the error.
  typedef struct packed {
    smp_t filt;
    err_t err;
  } fir_result_t;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  // [15:0] new_sample, [31:16] desired
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  // [15:0] filter_out, [32:16] error_out, [39:33] zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en   = 1'b0;
  logic [SHIFT_W-1:0]     cfg_wr_data = '0;

  // Items waiting for the driver, and results the block still owes us.
  logic [IN_TDATA_W-1:0] pending_items[$];
  fir_result_t           fir_results_due[$];

  // The bench's own copy of the filter state and the step register.
  smp_t   tap_hist[TAPS];
  longint tap_coef[TAPS];
  int     step_now;

  int cycle_count    = 0;
  int mismatches     = 0;
  int items_queued   = 0;
  int results_seen   = 0;
  int settings_used  = 0;
  int burst_left     = 0;
  int gap_left       = 0;
  int rx_count       = 0;
  logic [31:0] rdy_pattern = 32'hFFFF_FFFF;

  // A plant that the filter can learn, so that most items are a coherent signal
  // rather than noise. Coefficients are in units of 1/256.
  int plant_coef[TAPS];
  int plant_hist[TAPS];

  lms_adaptive_fir #(
    .TAPS(TAPS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // ---------------------------------------------------------------------------
  // Predictor arithmetic. SystemVerilog addition wraps, so overflow is detected
  // from the signs of the operands and the sum.
  // ---------------------------------------------------------------------------
  function automatic longint sat_sum64(longint a, longint b);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      return a[63] ? W_MIN : W_MAX;
    end
    return s;
  endfunction

  // Weight change for one tap given error*sample. Up to a shift of 48 the
  // product is scaled up into Q16.48 and clamped; beyond that it is scaled
  // down with a floor, which is what an arithmetic right shift gives.
  function automatic longint coef_step(longint p);
    int     k;
    longint lim;
    if (step_now <= 48) begin
      k   = 48 - step_now;
      lim = W_MAX >>> k;
      if (p > lim) begin
        return W_MAX;
      end
      if (p < -lim - 1) begin
        return W_MIN;
      end
      return p <<< k;
    end
    return p >>> (step_now - 48);
  endfunction

  // Advance the bench's filter by one item and queue the result it must produce.
  // The new sample enters the delay line before filtering, and the weight update
  // uses the same delay line contents that the filtering saw.
  task automatic predict_fir_item(input smp_t smp, input smp_t want);
    longint      acc;
    longint      y;
    longint      e;
    fir_result_t r;
    for (int i = TAPS - 1; i > 0; i--) begin
      tap_hist[i] = tap_hist[i-1];
    end
    tap_hist[0] = smp;
    acc = 0;
    for (int i = 0; i < TAPS; i++) begin
      // Only the Q16.16 part of each weight takes part in the filtering.
      acc = sat_sum64(acc, (tap_coef[i] >>> 32) * longint'(tap_hist[i]));
    end
    y = acc >>> 16;
    if (y > 32767) begin
      y = 32767;
    end
    if (y < -32768) begin
      y = -32768;
    end
    e = longint'(want) - y;
    for (int i = 0; i < TAPS; i++) begin
      tap_coef[i] = sat_sum64(tap_coef[i], coef_step(e * longint'(tap_hist[i])));
    end
    r.filt = smp_t'(y);
    r.err  = err_t'(e);
    fir_results_due.push_back(r);
  endtask

  // One line per mismatch, with printing capped so a broken block cannot flood the log.
  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatches < 20) begin
      $display("MISMATCH at cycle %0d, result %0d: %s got %0d expected %0d",
               cycle_count, results_seen, what, got, want);
    end
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: sends the pending items in bursts of random length with random
  // gaps. A presented item is held until it is taken. Gaps are sometimes zero,
  // so long stretches arrive back to back, and sometimes longer than the
  // block's processing time, so they land on every phase of its work.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        void'(pending_items.pop_front());
      end
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pending_items[0];
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left--;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: out_tready follows a rotating 32-bit pattern that is replaced
  // at regular intervals. Patterns range from always ready through random to
  // mostly stalled; bit 0 is kept high so the receiver never stalls forever.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_count++;
      if (rx_count % 256 == 0) begin
        case ($urandom_range(0, 3))
          0:       rdy_pattern = 32'hFFFF_FFFF;
          1:       rdy_pattern = $urandom;
          2:       rdy_pattern = $urandom | $urandom;
          default: rdy_pattern = $urandom & $urandom & $urandom;
        endcase
        rdy_pattern[0] = 1'b1;
      end
      out_tready  <= rdy_pattern[0];
      rdy_pattern = {rdy_pattern[0], rdy_pattern[31:1]};
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: tracks register writes, predicts on every accepted input item and
  // checks every accepted result against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    fir_result_t due;
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) begin
        tap_hist[i] = '0;
        tap_coef[i] = 0;
      end
      step_now = int'(STEP_RESET);
    end else begin
      if (cfg_wr_en) begin
        step_now = int'(cfg_wr_data);
      end
      if (in_tvalid && in_tready) begin
        predict_fir_item(smp_t'(in_tdata[SMP_W-1:0]), smp_t'(in_tdata[2*SMP_W-1:SMP_W]));
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (fir_results_due.size() == 0) begin
          report_mismatch("unexpected result, filter_out", longint'(smp_t'(out_tdata[15:0])), 0);
        end else begin
          due = fir_results_due.pop_front();
          if (out_tdata[SMP_W-1:0] !== due.filt) begin
            report_mismatch("filter_out", longint'(smp_t'(out_tdata[SMP_W-1:0])),
                            longint'(due.filt));
          end
          if (out_tdata[OUT_PAD_LSB-1:SMP_W] !== due.err) begin
            report_mismatch("error_out", longint'(err_t'(out_tdata[OUT_PAD_LSB-1:SMP_W])),
                            longint'(due.err));
          end
          if (out_tdata[OUT_TDATA_W-1:OUT_PAD_LSB] !== '0) begin
            report_mismatch("padding", longint'(out_tdata[OUT_TDATA_W-1:OUT_PAD_LSB]), 0);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic queue_item(input smp_t smp, input smp_t want);
    pending_items.push_back({want, smp});
    items_queued++;
  endtask

  // Waits until the block has nothing in flight, then lets it settle.
  task automatic wait_quiet();
    while (pending_items.size() != 0 || in_tvalid || fir_results_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_step_shift(input shift_t value);
    wait_quiet();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    settings_used++;
  endtask

  // Random items. Most carry a desired value produced by a hidden FIR plant
  // from the same samples, so the weights actually converge and the later
  // states of the filter are reached; the rest are unrelated noise or extremes.
  // The sample amplitude changes every 40 items to exercise both tiny and
  // full-scale signals.
  task automatic queue_random(input int count);
    int   amp;
    int   sum;
    int   kind;
    smp_t smp;
    smp_t want;
    amp = 32767;
    for (int j = 0; j < TAPS; j++) begin
      plant_coef[j] = int'($urandom_range(0, 256)) - 128;
    end
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 3))
          0:       amp = 32767;
          1:       amp = 4095;
          2:       amp = 255;
          default: amp = 15;
        endcase
      end
      smp = smp_t'(int'($urandom_range(0, 2 * amp + 1)) - amp - 1);
      for (int j = TAPS - 1; j > 0; j--) begin
        plant_hist[j] = plant_hist[j-1];
      end
      plant_hist[0] = int'(smp);
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        sum = 0;
        for (int j = 0; j < TAPS; j++) begin
          sum += plant_coef[j] * plant_hist[j];
        end
        sum = (sum >>> 8) + int'($urandom_range(0, 6)) - 3;
        if (sum > 32767) begin
          sum = 32767;
        end
        if (sum < -32768) begin
          sum = -32768;
        end
        want = smp_t'(sum);
      end else if (kind < 9) begin
        want = smp_t'($urandom);
      end else begin
        want = ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
      end
      queue_item(smp, want);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Timeout: a hung handshake ends the run as a failure.
  // ---------------------------------------------------------------------------
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles with %0d results outstanding",
             cycle_count, fir_results_due.size());
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, a directed set at the reset step size, then random
  // phases under a series of step sizes. The series covers the extremes (zero,
  // which drives the weights into saturation, and the largest code, where the
  // update is scaled down with a floored right shift) as well as the nominal 0..48
  // range. Weights carry over from phase to phase, as they would in use.
  // ---------------------------------------------------------------------------
  initial begin
    shift_t steps[10];
    steps = '{6'd30, 6'd48, 6'd44, 6'd20, 6'd55, 6'd63, 6'd0, 6'd12, 6'd40, 6'd37};
    for (int j = 0; j < TAPS; j++) begin
      plant_hist[j] = 0;
    end
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items: full-scale samples and desired values of both signs,
    // including the largest possible error, zero, and minus one.
    queue_item(16'sd0,      16'sd0);
    queue_item(16'sh7FFF,   16'sh7FFF);
    queue_item(16'sh8000,   16'sh8000);
    queue_item(16'sh7FFF,   16'sh8000);
    queue_item(16'sh8000,   16'sh7FFF);
    queue_item(-16'sd1,     16'sd0);
    queue_item(16'sd1,      -16'sd1);
    queue_item(16'sd0,      16'sh7FFF);
    queue_item(16'sd0,      16'sh8000);
    queue_item(-16'sd1,     -16'sd1);
    for (int n = 0; n < 4; n++) begin
      queue_item(16'sh8000, 16'sh8000);
    end
    for (int n = 0; n < 4; n++) begin
      queue_item(16'sh7FFF, 16'sh7FFF);
    end
    queue_item(16'sd12345,  -16'sd23456);
    queue_item(-16'sd21846, 16'sd21845);
    queue_random(PHASE_LEN);

    // The register is written under each setting in turn.
    foreach (steps[p]) begin
      write_step_shift(steps[p]);
      queue_random(PHASE_LEN);
    end

    wait_quiet();
    $display("run covered %0d items and %0d results under %0d register settings",
             items_queued, results_seen, settings_used + 1);
    $display("step shifts from 0 to 63 were used, %0d mismatches found", mismatches);
    if (mismatches == 0 && fir_results_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/laf_pkg.sv
hdl/lms_adaptive_fir.sv
hdl/laf_port_checker.sv
verif/lms_adaptive_fir_test.sv
